[design/sha1mh_pkg.sv]
// Shared types, constants and helper functions for the SHA-1 message hasher.
`default_nettype none

package sha1mh_pkg;

    localparam int WORD_W    = 32;
    localparam int BLK_WORDS = 16;
    localparam int BLK_AW    = 4;
    localparam int CHAIN_N   = 5;
    localparam int CHAIN_AW  = 3;
    localparam int LEN_W     = 61;
    localparam int ROUNDS    = 80;

    localparam logic [7:0]          PAD_BYTE  = 8'h80;
    localparam logic [CHAIN_AW-1:0] LAST_WORD = 3'(CHAIN_N - 1);

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [2:0]        word_number;
        logic              final_word;
    } out_item_t;

    typedef logic [CHAIN_N-1:0][WORD_W-1:0] rvars_t;

    typedef enum logic [1:0] {
        RS_CHOOSE = 2'd0,
        RS_PAR_LO = 2'd1,
        RS_MAJ    = 2'd2,
        RS_PAR_HI = 2'd3
    } rstage_t;

    typedef struct packed {
        logic    en;
        logic    early;
        rstage_t stage;
    } rnd_ctl_t;

    function automatic logic [WORD_W-1:0] init_word(input logic [CHAIN_AW-1:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input rstage_t st);
        logic [WORD_W-1:0] k;
        case (st)
            RS_CHOOSE: k = 32'h5A827999;
            RS_PAR_LO: k = 32'h6ED9EBA1;
            RS_MAJ:    k = 32'h8F1BBCDC;
            RS_PAR_HI: k = 32'hCA62C1D6;
            default:   k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[design/sha1mh_block_mem.sv]
// Block buffer: 16 x 32-bit message words, one write and one registered read port.
`default_nettype none

module sha1mh_block_mem (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [sha1mh_pkg::BLK_AW-1:0]     wa,
    input  wire logic [sha1mh_pkg::WORD_W-1:0]     wd,
    input  wire logic [sha1mh_pkg::BLK_AW-1:0]     ra,
    output logic      [sha1mh_pkg::WORD_W-1:0]     rd
);
    import sha1mh_pkg::*;

    logic [WORD_W-1:0] mem [BLK_WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

`default_nettype wire

[design/sha1mh_chain_mem.sv]
// Chaining-word store: 5 x 32-bit memory that reads as the initial vector until rewritten.
`default_nettype none

module sha1mh_chain_mem (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              we,
    input  wire logic [sha1mh_pkg::CHAIN_AW-1:0]   wa,
    input  wire logic [sha1mh_pkg::WORD_W-1:0]     wd,
    input  wire logic [sha1mh_pkg::CHAIN_AW-1:0]   ra,
    input  wire logic                              iv_set,
    input  wire logic                              iv_clr,
    output logic      [sha1mh_pkg::WORD_W-1:0]     rd
);
    import sha1mh_pkg::*;

    logic [WORD_W-1:0] mem [CHAIN_N];
    logic              iv_reg;

    // iv_reg high: contents are stale, reads return the initial vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b1;
        end
        else if (iv_set)
        begin
            iv_reg <= 1'b1;
        end
        else if (iv_clr)
        begin
            iv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= iv_reg ? init_word(ra) : mem[ra];
    end

endmodule

`default_nettype wire

[design/sha1mh_round.sv]
// One SHA-1 round per cycle with the 16-word message schedule shift line.
`default_nettype none

module sha1mh_round (
    input  wire logic                              clk,
    input  wire sha1mh_pkg::rnd_ctl_t              ctl,
    input  wire logic [sha1mh_pkg::WORD_W-1:0]     blk_word,
    input  wire sha1mh_pkg::rvars_t                vars_in,
    output sha1mh_pkg::rvars_t                     vars_out
);
    import sha1mh_pkg::*;

    logic [WORD_W-1:0] sw_reg [BLK_WORDS];
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] a, b, c, d, e;

    always_comb
    begin
        a   = vars_in[0];
        b   = vars_in[1];
        c   = vars_in[2];
        d   = vars_in[3];
        e   = vars_in[4];
        mix = sw_reg[13] ^ sw_reg[8] ^ sw_reg[2] ^ sw_reg[0];
        w   = ctl.early ? blk_word : {mix[30:0], mix[31]};
        case (ctl.stage)
            RS_CHOOSE: f = (b & c) | (~b & d);
            RS_MAJ:    f = (b & c) | (b & d) | (c & d);
            default:   f = b ^ c ^ d;
        endcase
        vars_out[0] = {a[26:0], a[31:27]} + f + e + round_const(ctl.stage) + w;
        vars_out[1] = a;
        vars_out[2] = {b[1:0], b[31:2]};
        vars_out[3] = c;
        vars_out[4] = d;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                sw_reg[i] <= sw_reg[i + 1];
            end
            sw_reg[BLK_WORDS - 1] <= w;
        end
    end

endmodule

`default_nettype wire

[design/sha1_message_hasher.sv]
// SHA-1 message hasher top level: byte gathering, padding, compression sequencer, digest output.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | in_data  (msg_byte, byte_present, end_of_message)
//   out     | output    | out_valid / out_ready   | out_data (digest_word, word_number, final_word)
//
// A byte that does not complete a block is taken with no further work. A byte completing a
// 64-byte block starts a compression: chaining-word load, 80 rounds, chaining-word writeback;
// load and writeback use the single chain-memory port; the datapath does one round per cycle.
// An end transaction writes up to 16 padding words per block, runs one or two compressions, then
// emits five digest words, each read (DREAD) and then shown (DSHOW), waiting on any output stall.
// Reset needs no clearing pass: the chain store reads as the initial vector until written.
`default_nettype none

module sha1_message_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sha1mh_pkg::in_item_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output sha1mh_pkg::out_item_t      out_data
);
    import sha1mh_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LOAD    = 8'b0000_0010,
        ST_ROUND   = 8'b0000_0100,
        ST_WB      = 8'b0000_1000,
        ST_PADHEAD = 8'b0001_0000,
        ST_PADZERO = 8'b0010_0000,
        ST_DREAD   = 8'b0100_0000,
        ST_DSHOW   = 8'b1000_0000
    } state_t;

    localparam logic [CHAIN_AW-1:0] STEP_LAST = 3'(CHAIN_N);
    localparam logic [6:0]          RND_LAST  = 7'(ROUNDS - 1);
    localparam logic [6:0]          RND_EARLY = 7'(BLK_WORDS);
    localparam logic [BLK_AW-1:0]   LEN_HI_W  = 4'(BLK_WORDS - 2);
    localparam logic [BLK_AW-1:0]   LEN_LO_W  = 4'(BLK_WORDS - 1);

    state_t              state_reg;
    logic [CHAIN_AW-1:0] step_reg;
    logic [6:0]          rnd_reg;
    logic [BLK_AW:0]     pw_reg;
    logic [CHAIN_AW-1:0] oi_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                pend_end_reg;
    logic                pad_active_reg;
    logic                final_pass_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   acc_reg;
    rvars_t              rv_reg;
    out_item_t           out_data_reg;

    logic                accept;
    logic [5:0]          fill;
    logic [1:0]          bpos;
    logic [BLK_AW-1:0]   wi;
    logic [4:0]          bsh;
    logic [WORD_W-1:0]   acc_next;
    logic [WORD_W-1:0]   pad_word;
    logic [63:0]         len_bits;
    logic [CHAIN_AW-1:0] step_prev;

    logic                bw_en;
    logic [BLK_AW-1:0]   bw_addr;
    logic [WORD_W-1:0]   bw_data;
    logic [BLK_AW-1:0]   br_addr;
    logic [WORD_W-1:0]   blk_q;

    logic                ch_we;
    logic [CHAIN_AW-1:0] ch_ra;
    logic [WORD_W-1:0]   ch_wd;
    logic [WORD_W-1:0]   ch_q;
    logic                iv_set;
    logic                iv_clr;

    rnd_ctl_t            rctl;
    rvars_t              rv_new;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid && in_ready;
        fill      = len_reg[5:0];
        bpos      = fill[1:0];
        wi        = fill[5:2];
        bsh       = {~bpos, 3'b000};
        acc_next  = (acc_reg & ~(32'h0000_00FF << bsh)) | ({24'h0, in_data.msg_byte} << bsh);
        pad_word  = (acc_reg & ~(32'hFFFF_FFFF >> {bpos, 3'b000}))
                  | ({PAD_BYTE, 24'h0} >> {bpos, 3'b000});
        len_bits  = {len_reg, 3'b000};
        step_prev = step_reg - 3'd1;

        bw_en   = 1'b0;
        bw_addr = wi;
        bw_data = acc_next;
        case (state_reg)
            ST_IDLE:
            begin
                bw_en = accept && in_data.byte_present && (bpos == 2'd3);
            end
            ST_PADHEAD:
            begin
                bw_en   = 1'b1;
                bw_data = pad_word;
            end
            ST_PADZERO:
            begin
                bw_en   = !pw_reg[BLK_AW];
                bw_addr = pw_reg[BLK_AW-1:0];
                bw_data = '0;
                if (final_pass_reg && pw_reg[BLK_AW-1:0] == LEN_HI_W)
                begin
                    bw_data = len_bits[63:32];
                end
                else if (final_pass_reg && pw_reg[BLK_AW-1:0] == LEN_LO_W)
                begin
                    bw_data = len_bits[31:0];
                end
            end
            default:
            begin
                bw_en = 1'b0;
            end
        endcase

        br_addr = (state_reg == ST_ROUND) ? (rnd_reg[BLK_AW-1:0] + 4'd1) : '0;

        ch_ra = '0;
        if (state_reg == ST_DREAD)
        begin
            ch_ra = oi_reg;
        end
        else if (step_reg != STEP_LAST)
        begin
            ch_ra = step_reg;
        end
        ch_we  = (state_reg == ST_WB) && (step_reg != '0);
        ch_wd  = ch_q + rv_reg[step_prev];
        iv_clr = (state_reg == ST_WB) && (step_reg == STEP_LAST);
        iv_set = (state_reg == ST_DSHOW) && (oi_reg == LAST_WORD);

        rctl.en    = (state_reg == ST_ROUND);
        rctl.early = (rnd_reg < RND_EARLY);
        if (rnd_reg < 7'd20)
        begin
            rctl.stage = RS_CHOOSE;
        end
        else if (rnd_reg < 7'd40)
        begin
            rctl.stage = RS_PAR_LO;
        end
        else if (rnd_reg < 7'd60)
        begin
            rctl.stage = RS_MAJ;
        end
        else
        begin
            rctl.stage = RS_PAR_HI;
        end
    end

    sha1mh_block_mem u_block_mem (
        .clk (clk),
        .we  (bw_en),
        .wa  (bw_addr),
        .wd  (bw_data),
        .ra  (br_addr),
        .rd  (blk_q)
    );

    sha1mh_chain_mem u_chain_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (ch_we),
        .wa     (step_prev),
        .wd     (ch_wd),
        .ra     (ch_ra),
        .iv_set (iv_set),
        .iv_clr (iv_clr),
        .rd     (ch_q)
    );

    sha1mh_round u_round (
        .clk      (clk),
        .ctl      (rctl),
        .blk_word (blk_q),
        .vars_in  (rv_reg),
        .vars_out (rv_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            rnd_reg        <= '0;
            pw_reg         <= '0;
            oi_reg         <= '0;
            len_reg        <= '0;
            pend_end_reg   <= 1'b0;
            pad_active_reg <= 1'b0;
            final_pass_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DSHOW)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_data.byte_present)
                        begin
                            len_reg <= len_reg + 61'd1;
                        end
                        if (in_data.byte_present && fill == 6'd63)
                        begin
                            state_reg    <= ST_LOAD;
                            step_reg     <= '0;
                            pend_end_reg <= in_data.end_of_message;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_reg <= ST_PADHEAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_ROUND;
                        rnd_reg   <= '0;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == RND_LAST)
                    begin
                        state_reg <= ST_WB;
                        step_reg  <= '0;
                    end
                end
                ST_WB:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        if (pad_active_reg && final_pass_reg)
                        begin
                            state_reg <= ST_DREAD;
                            oi_reg    <= '0;
                        end
                        else if (pad_active_reg)
                        begin
                            state_reg      <= ST_PADZERO;
                            pw_reg         <= '0;
                            final_pass_reg <= 1'b1;
                        end
                        else if (pend_end_reg)
                        begin
                            state_reg    <= ST_PADHEAD;
                            pend_end_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_PADHEAD:
                begin
                    pad_active_reg <= 1'b1;
                    pend_end_reg   <= 1'b0;
                    pw_reg         <= {1'b0, wi} + 5'd1;
                    final_pass_reg <= (wi < LEN_HI_W);
                    state_reg      <= ST_PADZERO;
                end
                ST_PADZERO:
                begin
                    if (pw_reg[BLK_AW])
                    begin
                        state_reg <= ST_LOAD;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        pw_reg <= pw_reg + 5'd1;
                    end
                end
                ST_DREAD:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_DSHOW;
                    end
                end
                ST_DSHOW:
                begin
                    if (oi_reg == LAST_WORD)
                    begin
                        state_reg      <= ST_IDLE;
                        len_reg        <= '0;
                        pad_active_reg <= 1'b0;
                        final_pass_reg <= 1'b0;
                    end
                    else
                    begin
                        oi_reg    <= oi_reg + 3'd1;
                        state_reg <= ST_DREAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.byte_present)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_LOAD && step_reg != '0)
        begin
            rv_reg[step_prev] <= ch_q;
        end
        else if (state_reg == ST_ROUND)
        begin
            rv_reg <= rv_new;
        end
        if (state_reg == ST_DSHOW)
        begin
            out_data_reg.digest_word <= ch_q;
            out_data_reg.word_number <= oi_reg;
            out_data_reg.final_word  <= (oi_reg == LAST_WORD);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= RND_LAST))
        else $error("round counter out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSHOW && oi_reg == LAST_WORD) |=> (len_reg == '0 && state_reg == ST_IDLE))
        else $error("hasher did not restart after last digest word");

    a_pad_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PADZERO || state_reg == ST_DREAD) |-> pad_active_reg)
        else $error("padding or digest without active end of message");

    a_show_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSHOW) |-> !out_valid_reg)
        else $error("digest word would overwrite a pending transaction");

endmodule

`default_nettype wire

[dv/tb_sha1_message_hasher.sv]
// Self-checking testbench for the SHA-1 message hasher.
module tb_sha1_message_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1mh_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 48;
    localparam int          LONG_HOLD    = 800;
    localparam int          DRAIN_CYCLES = 300;
    localparam logic [159:0] DIGEST_EMPTY =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DIGEST_ABC =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam logic [31:0] IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] K_CHOOSE = 32'h5A827999;
    localparam logic [31:0] K_PAR_LO = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR_HI = 32'hCA62C1D6;

    typedef struct {
        in_item_t     item;
        bit           known;
        logic [159:0] digest;
    } stim_row_t;

    localparam int N_DIRECTED = 11;
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},
        '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h63, 1'b1, 1'b1}, 1'b1, DIGEST_ABC},
        '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'hA5, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},
        '{'{8'hFF, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
        '{'{8'h55, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'hAA, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // predictor state
    logic [31:0] chain_h [5];
    logic [7:0]  blk [64];
    logic [60:0] byte_count;
    out_item_t   pending_digest_words [$];

    int errors = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    sha1_message_hasher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void sha1_restart();
        for (int i = 0; i < 5; i++)
            chain_h[i] = IV[i];
        byte_count = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                wt = rotl(w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15], 1);
                w[r & 15] = wt;
            end
            else
                wt = w[r];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_PAR_LO;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PAR_HI;
            end
            t = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // absorb one transaction; on end of message queue the five digest words
    function automatic void sha1_absorb(input in_item_t it, input bit known,
                                        input logic [159:0] known_digest);
        int          fill;
        logic [63:0] bit_len;
        logic [31:0] word;
        fill = int'(byte_count[5:0]);
        if (it.byte_present)
        begin
            blk[fill] = it.msg_byte;
            byte_count = byte_count + 61'd1;
            if (fill == 63)
                sha1_compress();
        end
        if (!it.end_of_message)
            return;
        fill = int'(byte_count[5:0]);
        blk[fill] = PAD_BYTE;
        fill++;
        if (fill > 56)
        begin
            while (fill < 64)
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            sha1_compress();
            fill = 0;
        end
        while (fill < 56)
        begin
            blk[fill] = 8'h00;
            fill++;
        end
        bit_len = {byte_count, 3'b000};
        for (int i = 0; i < 8; i++)
            blk[63-i] = bit_len[8*i +: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++)
        begin
            word = known ? known_digest[159-32*i -: 32] : chain_h[i];
            pending_digest_words.push_back('{digest_word: word, word_number: 3'(i),
                                             final_word: (i == 4)});
        end
        sha1_restart();
    endfunction

    task automatic send_item(input in_item_t it, input bit known,
                             input logic [159:0] known_digest);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sha1_absorb(it, known, known_digest);
    endtask

    task automatic send_message(input int len, inout int sent);
        in_item_t it;
        bit       end_on_last;
        end_on_last = (len > 0) && ($urandom_range(1) == 1);
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(9) == 0)
            begin
                it.msg_byte       = 8'($urandom);
                it.byte_present   = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it, 1'b0, '0);
                sent++;
            end
            it.msg_byte       = 8'($urandom);
            it.byte_present   = 1'b1;
            it.end_of_message = end_on_last && (n == len - 1);
            send_item(it, 1'b0, '0);
            sent++;
        end
        if (!end_on_last)
        begin
            it.msg_byte       = 8'($urandom);
            it.byte_present   = 1'b0;
            it.end_of_message = 1'b1;
            send_item(it, 1'b0, '0);
            sent++;
        end
    endtask

    function automatic int pick_length(input bit short_only);
        int edge_lens [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        if (short_only)
            return $urandom_range(8);
        case ($urandom_range(9))
            0:       return edge_lens[$urandom_range(8)];
            1, 2:    return $urandom_range(64);
            default: return $urandom_range(12);
        endcase
    endfunction

    // output checker and ready generator
    always @(posedge clk)
    begin
        out_item_t exp_word;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_digest_words.size() == 0)
                begin
                    $display("%0t: expected no transaction actual %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    exp_word = pending_digest_words.pop_front();
                    if (out_data.digest_word !== exp_word.digest_word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 exp_word.digest_word, out_data.digest_word);
                        errors++;
                    end
                    if (out_data.word_number !== exp_word.word_number)
                    begin
                        $display("%0t: word_number expected %0d actual %0d", $time,
                                 exp_word.word_number, out_data.word_number);
                        errors++;
                    end
                    if (out_data.final_word !== exp_word.final_word)
                    begin
                        $display("%0t: final_word expected %b actual %b", $time,
                                 exp_word.final_word, out_data.final_word);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_seen)
                hold_left = LONG_HOLD;
            hold_seen = hold_req;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int src_pct [5] = '{0, 64, 0, 36, 0};
        int snk_pct [5] = '{0, 0, 64, 36, 0};
        int sent;
        sha1_restart();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].digest);

        for (int p = 0; p < 5; p++)
        begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            hold_req = (p == 4);
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_message(pick_length(p == 4), sent);
            in_valid <= 1'b0;
            while (pending_digest_words.size() != 0)
                @(posedge clk);
            hold_req = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
